@@ sv/buffered_interval_set_defines.svh @@
// Assertion macros shared by the checker of the interval set.
`ifndef BUFFERED_INTERVAL_SET_DEFINES_SVH
`define BUFFERED_INTERVAL_SET_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define BIS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define BIS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/bis_pkg.sv @@
// ----------------------------------------------------------------------------
// bis_pkg
// Shared constants, codes and control types of the buffered interval set.
// ----------------------------------------------------------------------------
package bis_pkg;

    localparam int MAX_RANGES_DEF = 16;
    localparam int TIME_BITS_DEF  = 48;
    localparam int TOL_BITS       = 20;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 20'd1000;

    localparam logic [1:0] CMD_ADD      = 2'd0;
    localparam logic [1:0] CMD_REMOVE   = 2'd1;
    localparam logic [1:0] CMD_CONTAINS = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_IGNORED = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    // Controls that every cell of the row receives.
    typedef struct packed {
        logic rotate;
        logic commit;
        logic push;
    } t_cell_ctl;

endpackage

@@ sv/buffered_interval_set.sv @@
// ----------------------------------------------------------------------------
// buffered_interval_set
// Sorted, disjoint table of half-open time ranges with add, remove and
// contains requests, held in a rotating row of cells.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// request   in         i_start, o_busy, i_command, i_start_time, i_end_time
// result    out        o_strobe, o_status, o_time_held, o_range_count,
//                      o_largest_end
// config    in         i_cfg_we, i_cfg_wdata (join tolerance)
//
// A request walks the row once, rotating it fully; the walk pauses on a head
// that is revisited when a stored range is split in two or when the merged
// range is placed ahead of a stored range. An ignored request skips the walk
// and goes straight to the result. The result shows for one cycle as o_strobe;
// the next request is taken the cycle after. Reset is synchronous and leaves
// the table empty; the receiver cannot stall the block.
module buffered_interval_set import bis_pkg::*; #(
    parameter int MAX_RANGES = MAX_RANGES_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [1:0]           i_command,
    input  logic [TIME_BITS-1:0] i_start_time,
    input  logic [TIME_BITS-1:0] i_end_time,
    input  logic                 i_cfg_we,
    input  logic [TOL_BITS-1:0]  i_cfg_wdata,
    output logic                 o_strobe,
    output logic [1:0]           o_status,
    output logic                 o_time_held,
    output logic [4:0]           o_range_count,
    output logic [TIME_BITS-1:0] o_largest_end
);

    localparam int KW = $clog2(2 * MAX_RANGES + 2);

    t_cell_ctl            ctl;
    logic [KW-1:0]        push_idx;
    logic [TIME_BITS-1:0] push_start, push_end;
    logic [TIME_BITS-1:0] c_start [MAX_RANGES];
    logic [TIME_BITS-1:0] c_end   [MAX_RANGES];

    bis_ctrl #(.MAX_RANGES(MAX_RANGES), .TIME_BITS(TIME_BITS), .KW(KW)) u_ctrl (
        .i_clk, .i_rst_n, .i_start, .i_command, .i_start_time, .i_end_time,
        .i_cfg_we, .i_cfg_wdata,
        .i_head_start(c_start[0]), .i_head_end(c_end[0]),
        .o_ctl(ctl), .o_push_idx(push_idx),
        .o_push_start(push_start), .o_push_end(push_end),
        .o_busy, .o_strobe, .o_status, .o_time_held, .o_range_count, .o_largest_end
    );

    // The head leaves cell 0 and re-enters at the far end of the row.
    for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
        bis_cell #(.TIME_BITS(TIME_BITS), .KW(KW), .IDX(g)) u_cell (
            .i_clk,
            .i_ctl(ctl),
            .i_push_idx(push_idx),
            .i_push_start(push_start),
            .i_push_end(push_end),
            .i_next_start(c_start[(g + 1) % MAX_RANGES]),
            .i_next_end(c_end[(g + 1) % MAX_RANGES]),
            .o_start(c_start[g]),
            .o_end(c_end[g])
        );
    end

endmodule

@@ sv/bis_cell.sv @@
// ----------------------------------------------------------------------------
// bis_cell
// One slot of the range table: a stored range that rotates to its neighbor,
// and a working range that is loaded when the push index hits this slot.
// ----------------------------------------------------------------------------
module bis_cell import bis_pkg::*; #(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int KW        = 6,
    parameter int IDX       = 0
) (
    input  logic                 i_clk,
    input  t_cell_ctl            i_ctl,
    input  logic [KW-1:0]        i_push_idx,
    input  logic [TIME_BITS-1:0] i_push_start,
    input  logic [TIME_BITS-1:0] i_push_end,
    input  logic [TIME_BITS-1:0] i_next_start,
    input  logic [TIME_BITS-1:0] i_next_end,
    output logic [TIME_BITS-1:0] o_start,
    output logic [TIME_BITS-1:0] o_end
);

    logic [TIME_BITS-1:0] r_start, r_end, r_tmp_start, r_tmp_end;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push && i_push_idx == KW'(IDX)) begin
            r_tmp_start <= i_push_start;
            r_tmp_end   <= i_push_end;
        end
        if (i_ctl.commit) begin
            r_start <= r_tmp_start;
            r_end   <= r_tmp_end;
        end else if (i_ctl.rotate) begin
            r_start <= i_next_start;
            r_end   <= i_next_end;
        end
    end

    assign o_start = r_start;
    assign o_end   = r_end;

endmodule

@@ sv/bis_ctrl.sv @@
// ----------------------------------------------------------------------------
// bis_ctrl
// Sequencer of the interval set: takes a request, looks at the head cell
// once per rotation step, decides the working ranges and commits them.
// ----------------------------------------------------------------------------
module bis_ctrl import bis_pkg::*; #(
    parameter int MAX_RANGES = MAX_RANGES_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int NW         = $clog2(MAX_RANGES + 1),
    parameter int KW         = $clog2(2 * MAX_RANGES + 2)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [1:0]           i_command,
    input  logic [TIME_BITS-1:0] i_start_time,
    input  logic [TIME_BITS-1:0] i_end_time,
    input  logic                 i_cfg_we,
    input  logic [TOL_BITS-1:0]  i_cfg_wdata,
    input  logic [TIME_BITS-1:0] i_head_start,
    input  logic [TIME_BITS-1:0] i_head_end,
    output t_cell_ctl            o_ctl,
    output logic [KW-1:0]        o_push_idx,
    output logic [TIME_BITS-1:0] o_push_start,
    output logic [TIME_BITS-1:0] o_push_end,
    output logic                 o_busy,
    output logic                 o_strobe,
    output logic [1:0]           o_status,
    output logic                 o_time_held,
    output logic [4:0]           o_range_count,
    output logic [TIME_BITS-1:0] o_largest_end
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WALK  = 4'b0010,
        S_FINAL = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [TOL_BITS-1:0]  r_tol;
    logic [1:0]           r_cmd;
    logic [TIME_BITS-1:0] r_s, r_e, r_lo, r_hi, n_lo, n_hi, r_last_end, n_last_end;
    logic [TIME_BITS-1:0] r_largest;
    logic [NW-1:0]        r_n, r_step, n_step;
    logic [KW-1:0]        r_k, n_k;
    logic                 r_placed, n_placed, r_half, n_half, r_held, n_held;
    logic [1:0]           r_status, n_status;
    logic                 n_commit;

    logic [TIME_BITS-1:0] tolx, rs, re;
    logic                 head_ok, below, above, cut_l, cut_r, ignore;
    logic [NW+4:0]        cnt_ext;

    assign tolx = TIME_BITS'(r_tol);
    assign rs   = i_head_start;
    assign re   = i_head_end;
    assign head_ok = r_step < r_n;
    assign below = (r_lo >= tolx) && (re < r_lo - tolx);
    assign above = (r_hi <= ~tolx) && (rs > r_hi + tolx);
    assign cut_l = (rs < r_s) && (r_s - rs >= tolx);
    assign cut_r = (re > r_e) && (re - r_e >= tolx);
    assign ignore = (i_command == CMD_ADD) ? (i_end_time <= i_start_time) :
                    (i_command == CMD_REMOVE) ?
                        ((i_end_time <= i_start_time) ||
                         (i_end_time - i_start_time < TIME_BITS'(r_tol))) :
                    (i_command != CMD_CONTAINS);

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_step      = r_step;
        n_k         = r_k;
        n_placed    = r_placed;
        n_half      = r_half;
        n_held      = r_held;
        n_status    = r_status;
        n_last_end  = r_last_end;
        n_commit    = 1'b0;
        o_ctl       = '0;
        o_push_start = rs;
        o_push_end   = re;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_lo     = i_start_time;
                    n_hi     = i_end_time;
                    n_step   = '0;
                    n_k      = '0;
                    n_placed = 1'b0;
                    n_half   = 1'b0;
                    n_held   = 1'b0;
                    n_status = ignore ? ST_IGNORED : ST_DONE;
                    n_state  = ignore ? S_DONE : S_WALK;
                end
            end
            S_WALK: begin
                o_ctl.rotate = 1'b1;
                if (head_ok) begin
                    case (r_cmd)
                        CMD_ADD: begin
                            if (below) begin
                                o_ctl.push = 1'b1;
                            end else if (above) begin
                                o_ctl.push = 1'b1;
                                if (!r_placed) begin
                                    // Place the merged range first, revisit this head.
                                    o_push_start = r_lo;
                                    o_push_end   = r_hi;
                                    n_placed     = 1'b1;
                                    o_ctl.rotate = 1'b0;
                                end
                            end else begin
                                if (rs < r_lo) n_lo = rs;
                                if (re > r_hi) n_hi = re;
                            end
                        end
                        CMD_REMOVE: begin
                            if (re <= r_s || rs >= r_e) begin
                                o_ctl.push = 1'b1;
                            end else if (cut_l && cut_r && !r_half) begin
                                o_ctl.push   = 1'b1;
                                o_push_end   = r_s;
                                n_half       = 1'b1;
                                o_ctl.rotate = 1'b0;
                            end else if (cut_r) begin
                                o_ctl.push   = 1'b1;
                                o_push_start = r_e;
                                n_half       = 1'b0;
                            end else if (cut_l) begin
                                o_ctl.push = 1'b1;
                                o_push_end = r_s;
                            end
                        end
                        default: begin
                            if (r_s >= rs && r_s < re) n_held = 1'b1;
                        end
                    endcase
                end
                if (o_ctl.rotate) begin
                    n_step = r_step + 1'b1;
                    if (r_step == NW'(MAX_RANGES - 1)) n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (r_cmd == CMD_ADD && !r_placed) begin
                    o_ctl.push   = 1'b1;
                    o_push_start = r_lo;
                    o_push_end   = r_hi;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (r_status == ST_DONE && r_cmd != CMD_CONTAINS) begin
                    if (r_k > KW'(MAX_RANGES)) n_status = ST_REFUSED;
                    else n_commit = 1'b1;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (o_ctl.push) begin
            n_k        = r_k + 1'b1;
            n_last_end = o_push_end;
        end
        o_ctl.commit = n_commit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_tol     <= TOL_RESET;
            r_n       <= '0;
            r_largest <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_tol <= i_cfg_wdata;
            if (n_commit) begin
                r_n       <= NW'(r_k);
                r_largest <= (r_k == '0) ? '0 : r_last_end;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_cmd <= i_command;
            r_s   <= i_start_time;
            r_e   <= i_end_time;
        end
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_step     <= n_step;
        r_k        <= n_k;
        r_placed   <= n_placed;
        r_half     <= n_half;
        r_held     <= n_held;
        r_status   <= n_status;
        r_last_end <= n_last_end;
    end

    assign o_push_idx = r_k;
    assign o_busy     = (r_state != S_IDLE);
    assign o_strobe   = (r_state == S_DONE);
    assign o_status   = n_status;
    assign o_time_held = r_held && (r_cmd == CMD_CONTAINS) && (r_status == ST_DONE);
    assign cnt_ext    = {5'd0, (n_commit ? NW'(r_k) : r_n)};
    assign o_range_count = cnt_ext[4:0];
    assign o_largest_end = n_commit ? ((r_k == '0) ? '0 : r_last_end) : r_largest;

endmodule

@@ sv/bis_checker.sv @@
// ----------------------------------------------------------------------------
// bis_checker
// Port-level checks of the interval set, bound to the top level.
// ----------------------------------------------------------------------------
`include "buffered_interval_set_defines.svh"

module bis_checker import bis_pkg::*; #(
    parameter int MAX_RANGES = MAX_RANGES_DEF
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_strobe,
    input logic [1:0] o_status,
    input logic [4:0] o_range_count
);

    `BIS_ASSERT_NEXT(a_accept_busy, i_start && !o_busy, o_busy || o_strobe, "request not taken")
    `BIS_ASSERT_NEXT(a_single_result, o_strobe, !o_strobe, "result shown twice")
    `BIS_ASSERT_NOW(a_result_busy, o_strobe, o_busy, "result while idle")
    `BIS_ASSERT_NOW(a_count_bound, o_strobe && o_status != ST_REFUSED,
        o_range_count <= 5'(MAX_RANGES), "count above capacity")

endmodule

bind buffered_interval_set bis_checker #(.MAX_RANGES(MAX_RANGES)) u_bis_checker (.*);

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the buffered interval set: a shadow range table
// predicts each response, random bursts drive add, remove and contains
// requests, and a monitor compares every strobed response in order.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bis_pkg::*;

    localparam int NRANGE = 16;
    localparam int TW     = 48;
    localparam logic [TW-1:0] TMAX = {TW{1'b1}};
    // Command code that the block does not implement.
    localparam logic [1:0] CMD_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]    cmd;
        logic [TW-1:0] t0;
        logic [TW-1:0] t1;
        logic          cfg;    // tolerance write instead of a request
        logic [19:0]   tol;
        logic          drain;  // wait until all responses are back
    } t_req;

    typedef struct packed {
        logic [1:0]    status;
        logic          held;
        logic [4:0]    count;
        logic [TW-1:0] last_end;
    } t_rsp;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_start = 0;
    logic o_busy;
    logic [1:0] i_command = CMD_ADD;
    logic [TW-1:0] i_start_time = '0;
    logic [TW-1:0] i_end_time = '0;
    logic i_cfg_we = 0;
    logic [19:0] i_cfg_wdata = '0;
    logic o_strobe;
    logic [1:0] o_status;
    logic o_time_held;
    logic [4:0] o_range_count;
    logic [TW-1:0] o_largest_end;

    buffered_interval_set u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_command(i_command), .i_start_time(i_start_time), .i_end_time(i_end_time),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata), .o_strobe(o_strobe),
        .o_status(o_status), .o_time_held(o_time_held),
        .o_range_count(o_range_count), .o_largest_end(o_largest_end)
    );

    initial forever #4 i_clk = ~i_clk;

    // Shadow table of the block.
    logic [TW-1:0] sh_lo [NRANGE];
    logic [TW-1:0] sh_hi [NRANGE];
    int            sh_n = 0;
    logic [19:0]   sh_tol = TOL_RESET;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    bit   failed = 0;
    bit   stim_done = 0;
    longint cycles = 0;

    task automatic queue_req(t_req r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    function automatic logic [1:0] table_commit(logic [TW-1:0] nlo[$], logic [TW-1:0] nhi[$]);
        if (nlo.size() > NRANGE) return ST_REFUSED;
        foreach (nlo[k]) begin
            sh_lo[k] = nlo[k];
            sh_hi[k] = nhi[k];
        end
        sh_n = nlo.size();
        return ST_DONE;
    endfunction

    function automatic logic [1:0] merge_range(logic [TW-1:0] s, logic [TW-1:0] e);
        logic [TW-1:0] lo, hi, tol;
        logic [TW-1:0] nlo[$], nhi[$];
        bit placed;
        lo = s; hi = e; tol = sh_tol; placed = 0;
        if (e <= s) return ST_IGNORED;
        for (int k = 0; k < sh_n; k++) begin
            if (lo >= tol && sh_hi[k] < lo - tol) begin
                nlo.insert(nlo.size(), sh_lo[k]); nhi.insert(nhi.size(), sh_hi[k]);
            end else if (hi <= TMAX - tol && sh_lo[k] > hi + tol) begin
                if (!placed) begin
                    nlo.insert(nlo.size(), lo); nhi.insert(nhi.size(), hi); placed = 1;
                end
                nlo.insert(nlo.size(), sh_lo[k]); nhi.insert(nhi.size(), sh_hi[k]);
            end else begin
                if (sh_lo[k] < lo) lo = sh_lo[k];
                if (sh_hi[k] > hi) hi = sh_hi[k];
            end
        end
        if (!placed) begin
            nlo.insert(nlo.size(), lo); nhi.insert(nhi.size(), hi);
        end
        return table_commit(nlo, nhi);
    endfunction

    function automatic logic [1:0] cut_range(logic [TW-1:0] s, logic [TW-1:0] e);
        logic [TW-1:0] tol;
        logic [TW-1:0] nlo[$], nhi[$];
        tol = sh_tol;
        if (e <= s || e - s < tol) return ST_IGNORED;
        for (int k = 0; k < sh_n; k++) begin
            if (sh_hi[k] <= s || sh_lo[k] >= e) begin
                nlo.insert(nlo.size(), sh_lo[k]); nhi.insert(nhi.size(), sh_hi[k]);
            end else begin
                if (sh_lo[k] < s && s - sh_lo[k] >= tol) begin
                    nlo.insert(nlo.size(), sh_lo[k]); nhi.insert(nhi.size(), s);
                end
                if (sh_hi[k] > e && sh_hi[k] - e >= tol) begin
                    nlo.insert(nlo.size(), e); nhi.insert(nhi.size(), sh_hi[k]);
                end
            end
        end
        return table_commit(nlo, nhi);
    endfunction

    function automatic t_rsp predict_rsp(t_req r);
        t_rsp p;
        p = '0;
        p.status = ST_IGNORED;
        if (r.cmd == CMD_ADD) p.status = merge_range(r.t0, r.t1);
        else if (r.cmd == CMD_REMOVE) p.status = cut_range(r.t0, r.t1);
        else if (r.cmd == CMD_CONTAINS) begin
            p.status = ST_DONE;
            for (int k = 0; k < sh_n; k++)
                if (r.t0 >= sh_lo[k] && r.t0 < sh_hi[k]) p.held = 1;
        end
        p.count = sh_n[4:0];
        p.last_end = (sh_n > 0) ? sh_hi[sh_n-1] : '0;
        return p;
    endfunction

    // Driver: bursts of requests separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;
    int cfg_wait = 0;
    always @(posedge i_clk) begin
        t_req r;
        logic cfg_we_nx;
        cfg_we_nx = 1'b0;
        if (!i_rst_n) begin
            i_start <= 0;
            i_cfg_we <= 0;
        end else begin
            if (i_start && !o_busy) begin
                // The request in flight is taken at this edge.
                expected_rsps.insert(expected_rsps.size(),
                                     predict_rsp(pending_reqs.pop_front()));
            end
            if (i_start && !o_busy || !i_start) begin
                if (pending_reqs.size() == 0) begin
                    i_start <= 0;
                    stim_done <= 1;
                end else if (pending_reqs[0].drain || pending_reqs[0].cfg) begin
                    i_start <= 0;
                    // The block may still be busy after an ignored request.
                    if (expected_rsps.size() != 0 || o_busy || i_start) cfg_wait <= 0;
                    else if (cfg_wait < 24) cfg_wait <= cfg_wait + 1;
                    else begin
                        r = pending_reqs.pop_front();
                        cfg_wait <= 0;
                        if (r.cfg) begin
                            cfg_we_nx = 1'b1;
                            i_cfg_wdata <= r.tol;
                            sh_tol = r.tol;
                        end
                    end
                end else if (gap_left > 0) begin
                    i_start <= 0;
                    gap_left <= gap_left - 1;
                end else begin
                    r = pending_reqs[0];
                    i_start <= 1;
                    i_command <= r.cmd;
                    i_start_time <= r.t0;
                    i_end_time <= r.t1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                    end else burst_left <= burst_left - 1;
                end
            end
            i_cfg_we <= cfg_we_nx;
        end
    end

    // Monitor: each strobe matches the oldest prediction.
    always @(posedge i_clk) begin
        t_rsp p;
        cycles <= cycles + 1;
        if (i_rst_n && o_strobe) begin
            if (expected_rsps.size() == 0) begin
                $error("response with none expected");
                failed = 1;
            end else begin
                p = expected_rsps.pop_front();
                if (o_status !== p.status) begin
                    $error("status exp %0d got %0d", p.status, o_status); failed = 1;
                end
                if (o_time_held !== p.held) begin
                    $error("time_held exp %0d got %0d", p.held, o_time_held); failed = 1;
                end
                if (o_range_count !== p.count) begin
                    $error("range_count exp %0d got %0d", p.count, o_range_count);
                    failed = 1;
                end
                if (o_largest_end !== p.last_end) begin
                    $error("largest_end exp %0h got %0h", p.last_end, o_largest_end);
                    failed = 1;
                end
            end
        end
    end

    function automatic t_req mk(logic [1:0] c, logic [TW-1:0] a, logic [TW-1:0] b);
        t_req r;
        r = '0;
        r.cmd = c; r.t0 = a; r.t1 = b;
        return r;
    endfunction

    function automatic t_req mk_cfg(logic [19:0] t);
        t_req r;
        r = '0;
        r.cfg = 1; r.tol = t;
        return r;
    endfunction

    function automatic logic [TW-1:0] rand_time(logic [TW-1:0] base);
        case ($urandom_range(0, 3))
            0: return TW'({$urandom, $urandom});
            1: return base + $urandom_range(0, 3000);
            default: return base + $urandom_range(0, 200000);
        endcase
    endfunction

    task automatic random_phase(int n, logic [TW-1:0] base);
        logic [TW-1:0] a, b;
        for (int k = 0; k < n; k++) begin
            a = rand_time(base);
            b = (($urandom_range(0, 9) == 0) ? rand_time(base) : a + $urandom_range(0, 40000));
            case ($urandom_range(0, 9))
                0, 1, 2, 3: queue_req(mk(CMD_ADD, a, b));
                4, 5, 6: queue_req(mk(CMD_REMOVE, a, b));
                7: queue_req(mk(CMD_NONE, a, b));
                default: queue_req(mk(CMD_CONTAINS, a, b));
            endcase
        end
    endtask

    initial begin
        t_req d;
        d = '0;
        d.drain = 1;
        // Directed: empty and narrow requests, edges of the time range, full table.
        queue_req(mk(CMD_CONTAINS, 0, 0));
        queue_req(mk(CMD_ADD, 100, 100));
        queue_req(mk(CMD_ADD, 0, 5000));
        queue_req(mk(CMD_ADD, 5500, 9000));
        queue_req(mk(CMD_ADD, TMAX - 10, TMAX));
        queue_req(mk(CMD_CONTAINS, TMAX - 1, 0));
        queue_req(mk(CMD_CONTAINS, 4999, TMAX));
        queue_req(mk(CMD_REMOVE, 2000, 2500));
        queue_req(mk(CMD_REMOVE, 2000, 1000));
        queue_req(mk(CMD_REMOVE, 1500, 3000));
        queue_req(mk(CMD_REMOVE, 0, TMAX));
        queue_req(mk(CMD_NONE, TMAX, TMAX));
        for (int k = 0; k < 17; k++)
            queue_req(mk(CMD_ADD, TW'(k * 10000), TW'(k * 10000 + 100)));
        queue_req(mk(CMD_REMOVE, 20, 5000));
        queue_req(d);
        queue_req(mk_cfg(20'd0));
        queue_req(mk(CMD_REMOVE, 30, 31));
        random_phase(180, 1000);
        queue_req(mk_cfg(20'hFFFFF));
        queue_req(mk(CMD_ADD, 0, 10));
        queue_req(mk(CMD_ADD, TMAX - 5, TMAX));
        random_phase(160, 2000000);
        queue_req(mk_cfg(20'h5A5A5));
        random_phase(160, TMAX - 300000);
        queue_req(mk_cfg(TOL_RESET));
        random_phase(160, 0);
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
    end

    initial begin
        wait (stim_done && expected_rsps.size() == 0);
        repeat (60) @(posedge i_clk);
        if (!failed && expected_rsps.size() == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin
        wait (cycles > 400000);
        $display("TB_ERROR");
        $finish;
    end
endmodule
